@@ rtl/llt_pkg.sv @@
// Shared types, constants and arithmetic helpers of the laser line triangulator.
// Used by the interfaces, controller, datapath and top level; depends on nothing.
package llt_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int OUT_W   = 16;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  localparam int DIV_STEPS = 60;
  localparam int MUL_STEPS = 16;
  localparam int CNT_W     = 6;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_FOCAL     = 3'd1;
  localparam logic [IDX_W-1:0] REG_DISTANCE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SINE      = 3'd3;
  localparam logic [IDX_W-1:0] REG_COSINE    = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd5;
  localparam logic [IDX_W-1:0] REG_CENTRE    = 3'd6;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PROD,
    CMD_DN,
    CMD_D1LOAD,
    CMD_DSTEP,
    CMD_RCALC,
    CMD_MXLOAD,
    CMD_MSTEP,
    CMD_MYLOAD,
    CMD_MZLOAD,
    CMD_TCALC,
    CMD_D2LOAD,
    CMD_FINISH,
    CMD_BAD
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic take;
  } ctl_t;

  typedef struct packed {
    logic need_calc;
    logic dn_pos;
  } stat_t;

  function automatic logic signed [44:0] round_q15(input logic [57:0] acc, input logic neg);
    logic [58:0] sum;
    logic [43:0] q;
    begin
      sum = {1'b0, acc} + 59'd16384;
      q = sum[58:15];
      round_q15 = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  endfunction

  function automatic logic [OUT_W-1:0] sat16(input logic signed [60:0] v);
    begin
      if (v > 61'sd32767) begin
        sat16 = 16'h7fff;
      end else if (v < -61'sd32768) begin
        sat16 = 16'h8000;
      end else begin
        sat16 = v[15:0];
      end
    end
  endfunction

endpackage

@@ rtl/llt_pix_if.sv @@
// Pixel input channel: valid/ready handshake with one pixel and its end marks.
// Depends on llt_pkg.
interface llt_pix_if import llt_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             row_end;
  logic             frame_end;
  modport source (output valid, pixel, row_end, frame_end, input ready);
  modport sink (input valid, pixel, row_end, frame_end, output ready);
endinterface

@@ rtl/llt_pt_if.sv @@
// Point output channel: valid/ready handshake with one triangulated point.
// Depends on llt_pkg.
interface llt_pt_if import llt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] row_index;
  logic [OUT_W-1:0]   x_pos;
  logic [OUT_W-1:0]   y_pos;
  logic [OUT_W-1:0]   z_pos;
  logic               invalid;
  logic               frame_last;
  modport source (output valid, row_index, x_pos, y_pos, z_pos, invalid, frame_last,
                  input ready);
  modport sink (input valid, row_index, x_pos, y_pos, z_pos, invalid, frame_last,
                output ready);
endinterface

@@ rtl/llt_cfg_if.sv @@
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on llt_pkg.
interface llt_cfg_if import llt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  reg_index;
  logic [DATA_W-1:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

@@ rtl/llt_datapath.sv @@
// Datapath: configuration registers, run tracking and the shared serial
// multiplier and divider of the triangulation. Depends on llt_pkg.
module llt_datapath import llt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  output stat_t              stat,
  input  logic [PIX_W-1:0]   pixel,
  input  logic               row_end,
  input  logic               frame_end,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]  cfg_data,
  output logic [COORD_W-1:0] row_index,
  output logic [OUT_W-1:0]   x_pos,
  output logic [OUT_W-1:0]   y_pos,
  output logic [OUT_W-1:0]   z_pos,
  output logic               invalid,
  output logic               frame_last
);

  logic [7:0]  thr;
  logic [15:0] focal;
  logic [15:0] cam_dist;
  logic [14:0] sn;
  logic [15:0] cs;
  logic [15:0] offs;
  logic [15:0] cen;

  logic [COORD_W-1:0] col_cnt;
  logic [COORD_W-1:0] row_cnt;
  logic               found;
  logic               closed;
  logic [COORD_W-1:0] rstart;
  logic [COORD_W-1:0] rstop;

  logic [COORD_W-1:0] c_start;
  logic [COORD_W-1:0] c_stop;
  logic [COORD_W-1:0] c_col;

  logic signed [31:0] prod_a;
  logic [30:0]        prod_b;
  logic [31:0]        prod_n;
  logic signed [44:0] dn;

  logic [59:0] dq;
  logic [46:0] rem;
  logic [45:0] den;

  logic        r_neg;
  logic [40:0] rmag;
  logic [57:0] mcand;
  logic [15:0] mplier;
  logic [57:0] acc;
  logic signed [44:0] xv;
  logic signed [44:0] yv;
  logic        t_neg;

  logic               hit;
  logic               row_done;
  logic [15:0]        f1;
  logic [12:0]        width;
  logic signed [14:0] uh;
  logic [46:0]        rem_sh;
  logic               ge;
  logic signed [60:0] rdiff;
  logic signed [41:0] rsat;
  logic signed [45:0] tval;
  logic [45:0]        tabs;
  logic signed [60:0] zv;
  logic [49:0]        d1_num;

  assign hit      = pixel > thr;
  assign row_done = row_end | frame_end;
  assign stat.need_calc = row_done & (found | hit);
  assign stat.dn_pos    = !dn[44] && (dn != 45'sd0);

  assign f1     = (focal == 16'd0) ? 16'd1 : focal;
  assign width  = {1'b0, c_col} + 13'd1;
  assign uh     = $signed({3'b0, c_start}) + $signed({3'b0, c_stop})
                - $signed({2'b0, width[12:1], 1'b0});
  assign rem_sh = {rem[45:0], dq[59]};
  assign ge     = rem_sh >= {1'b0, den};
  assign rdiff  = $signed({45'b0, cen}) - $signed({1'b0, dq});
  assign rsat   = (rdiff > 61'sd1099511627776) ? 42'sd1099511627776 :
                  (rdiff < -61'sd1099511627776) ? -42'sd1099511627776 : rdiff[41:0];
  assign tval   = $signed({30'b0, cam_dist}) - $signed({yv[44], yv});
  assign tabs   = tval[45] ? 46'(-tval) : tval;
  assign zv     = t_neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  assign d1_num = {1'b0, prod_n, 17'b0} + {6'b0, dn[43:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= 8'd200;
      focal    <= 16'd17302;
      cam_dist <= 16'd3200;
      sn       <= 15'd16384;
      cs       <= 16'd28378;
      offs     <= 16'd1847;
      cen      <= 16'd3695;
      col_cnt  <= '0;
      row_cnt  <= '0;
      found    <= 1'b0;
      closed   <= 1'b0;
      rstart   <= '0;
      rstop    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: thr      <= cfg_data[7:0];
          REG_FOCAL:     focal    <= cfg_data;
          REG_DISTANCE:  cam_dist <= cfg_data;
          REG_SINE:      sn       <= cfg_data[14:0];
          REG_COSINE:    cs       <= cfg_data;
          REG_OFFSET:    offs     <= cfg_data;
          REG_CENTRE:    cen      <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.take) begin
        if (row_done) begin
          col_cnt <= '0;
          found   <= 1'b0;
          closed  <= 1'b0;
          rstart  <= '0;
          rstop   <= '0;
          if (frame_end) begin
            row_cnt <= '0;
          end else if (row_cnt != COORD_MAX) begin
            row_cnt <= row_cnt + 1'b1;
          end
        end else begin
          if (col_cnt != COORD_MAX) begin
            col_cnt <= col_cnt + 1'b1;
          end
          if (hit) begin
            if (!found) begin
              found  <= 1'b1;
              rstart <= col_cnt;
              rstop  <= col_cnt;
            end else if (!closed) begin
              rstop <= col_cnt;
            end
          end else if (found) begin
            closed <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && row_done) begin
      c_start    <= (hit && !found) ? col_cnt : rstart;
      c_stop     <= (hit && (!found || !closed)) ? col_cnt : rstop;
      c_col      <= col_cnt;
      row_index  <= row_cnt;
      frame_last <= frame_end;
    end
    case (ctl.cmd)
      CMD_PROD: begin
        prod_a <= uh * $signed({1'b0, cs});
        prod_b <= f1 * sn;
        prod_n <= offs * f1;
      end
      CMD_DN: begin
        dn <= $signed({{9{prod_a[31]}}, prod_a, 4'b0}) + $signed({13'b0, prod_b, 1'b0});
      end
      CMD_D1LOAD: begin
        dq  <= {10'b0, d1_num};
        den <= {dn[44:0], 1'b0};
        rem <= '0;
      end
      CMD_DSTEP: begin
        rem <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
        dq  <= {dq[58:0], ge};
      end
      CMD_RCALC: begin
        r_neg <= rsat[41];
        rmag  <= rsat[41] ? 41'(-rsat) : rsat[40:0];
      end
      CMD_MXLOAD: begin
        mcand  <= {17'b0, rmag};
        mplier <= {1'b0, sn};
        acc    <= '0;
      end
      CMD_MSTEP: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[56:0], 1'b0};
        mplier <= {1'b0, mplier[15:1]};
      end
      CMD_MYLOAD: begin
        xv     <= round_q15(acc, r_neg);
        mcand  <= {17'b0, rmag};
        mplier <= cs;
        acc    <= '0;
      end
      CMD_MZLOAD: begin
        yv <= round_q15(acc, r_neg);
      end
      CMD_TCALC: begin
        t_neg  <= tval[45];
        mcand  <= {16'b0, tabs[41:0]};
        mplier <= {row_index, 4'b0};
        acc    <= '0;
      end
      CMD_D2LOAD: begin
        dq  <= {1'b0, {1'b0, acc} + {44'b0, f1[15:1]}};
        den <= {30'b0, f1};
        rem <= '0;
      end
      CMD_FINISH: begin
        x_pos   <= sat16(61'(xv));
        y_pos   <= sat16(61'(yv));
        z_pos   <= sat16(zv);
        invalid <= 1'b0;
      end
      CMD_BAD: begin
        x_pos   <= '0;
        y_pos   <= '0;
        z_pos   <= '0;
        invalid <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/llt_ctrl.sv @@
// Controller: sequences pixel intake, the triangulation steps and result hand-off.
// Depends on llt_pkg.
module llt_ctrl import llt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctl_t  ctl
);

  typedef enum logic [4:0] {
    S_IDLE, S_PROD, S_DN, S_CHK, S_D1LD, S_D1, S_RCALC, S_MXLD, S_MX, S_MYLD, S_MY,
    S_MZLD, S_TCALC, S_MZ, S_D2LD, S_D2, S_FIN, S_BAD, S_OUT
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  cmd_t             cmd;
  cmd_t             cmd_next;
  logic             div_last;
  logic             mul_last;

  assign div_last = cnt == CNT_W'(DIV_STEPS - 1);
  assign mul_last = cnt == CNT_W'(MUL_STEPS - 1);
  assign ctl.cmd  = cmd;
  assign ctl.take = in_valid & in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid && in_ready && stat.need_calc) state_next = S_PROD;
      S_PROD:  state_next = S_DN;
      S_DN:    state_next = S_CHK;
      S_CHK:   state_next = stat.dn_pos ? S_D1LD : S_BAD;
      S_D1LD:  state_next = S_D1;
      S_D1:    if (div_last) state_next = S_RCALC;
      S_RCALC: state_next = S_MXLD;
      S_MXLD:  state_next = S_MX;
      S_MX:    if (mul_last) state_next = S_MYLD;
      S_MYLD:  state_next = S_MY;
      S_MY:    if (mul_last) state_next = S_MZLD;
      S_MZLD:  state_next = S_TCALC;
      S_TCALC: state_next = S_MZ;
      S_MZ:    if (mul_last) state_next = S_D2LD;
      S_D2LD:  state_next = S_D2;
      S_D2:    if (div_last) state_next = S_FIN;
      S_FIN:   state_next = S_OUT;
      S_BAD:   state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    unique case (state_next)
      S_PROD:  cmd_next = CMD_PROD;
      S_DN:    cmd_next = CMD_DN;
      S_D1LD:  cmd_next = CMD_D1LOAD;
      S_D1:    cmd_next = CMD_DSTEP;
      S_D2:    cmd_next = CMD_DSTEP;
      S_RCALC: cmd_next = CMD_RCALC;
      S_MXLD:  cmd_next = CMD_MXLOAD;
      S_MX:    cmd_next = CMD_MSTEP;
      S_MY:    cmd_next = CMD_MSTEP;
      S_MZ:    cmd_next = CMD_MSTEP;
      S_MYLD:  cmd_next = CMD_MYLOAD;
      S_MZLD:  cmd_next = CMD_MZLOAD;
      S_TCALC: cmd_next = CMD_TCALC;
      S_D2LD:  cmd_next = CMD_D2LOAD;
      S_FIN:   cmd_next = CMD_FINISH;
      S_BAD:   cmd_next = CMD_BAD;
      default: cmd_next = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmd       <= CMD_NONE;
      cnt       <= '0;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmd       <= cmd_next;
      cnt       <= (state_next == state) ? cnt + 1'b1 : '0;
      in_ready  <= state_next == S_IDLE;
      out_valid <= state_next == S_OUT;
    end
  end

endmodule

@@ rtl/laser_line_triangulator.sv @@
// Laser line triangulator top level: joins controller, datapath and channels.
// Depends on llt_pkg, llt_pix_if, llt_pt_if, llt_cfg_if, llt_ctrl and llt_datapath.
//
// Pixels enter on the pix channel in raster order, one item per cycle while pix ready is high, with
// row_end on a row's last pixel and frame_end on the frame's last pixel.
// In each row the first run of pixels above the threshold is tracked. An end
// pixel of a row holding a run starts the triangulation, and one point item
// leaves on the pt channel; rows without a run produce nothing and do not stall the pix channel.
// Triangulation shares one bit-serial divider and one shift-add multiplier:
// two 60-step divisions and three 16-step multiplications plus the setup steps
// run between the acceptance of the end pixel and the rise of pt valid.
// A bad geometry (non-positive denominator) skips the math and sends an invalid point.
// While a point is computed or waits on the pt channel, pix ready stays low; it is
// high again in the cycle after the point item is taken. A stalled receiver holds it.
// Configuration writes on the cfg channel are taken at any time, ready held high.
// Reset is synchronous: registers return to their defaults, run and row counters
// clear, and pix ready rises in the cycle after reset is released.
module laser_line_triangulator import llt_pkg::*; (
  input logic      clk,
  input logic      rst,
  llt_pix_if.sink  pix,
  llt_pt_if.source pt,
  llt_cfg_if.sink  cfg
);

  ctl_t  ctl;
  stat_t stat;

  assign cfg.ready = 1'b1;

  llt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (pt.valid),
    .out_ready (pt.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  llt_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .pixel      (pix.pixel),
    .row_end    (pix.row_end),
    .frame_end  (pix.frame_end),
    .cfg_we     (cfg.valid & cfg.ready),
    .cfg_index  (cfg.reg_index),
    .cfg_data   (cfg.wr_data),
    .row_index  (pt.row_index),
    .x_pos      (pt.x_pos),
    .y_pos      (pt.y_pos),
    .z_pos      (pt.z_pos),
    .invalid    (pt.invalid),
    .frame_last (pt.frame_last)
  );

endmodule
